/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define SCRD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/scrd_pkg.sv */
`default_nettype none
package scrd_pkg;

  localparam int MAX_PARAM   = 16;
  localparam int STORE_DEPTH = 16;
  localparam int PARAM_LIMIT = (MAX_PARAM > STORE_DEPTH) ? STORE_DEPTH : MAX_PARAM;
  localparam int FIXED_BYTES = 4;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_SUM_ERR = 2'd1,
    ST_END_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_HDR1 = 2'd0,
    CFG_HDR2 = 2'd1,
    CFG_END  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        command;
    logic [7:0]        function_code;
    logic [7:0]        channel_id;
    logic [CNT_W-1:0]  param_count;
  } frame_meta_t;

endpackage
`default_nettype wire

/* src/sum_checked_response_deframer_unit.sv */
// Results: once a frame's end byte (or bad length byte) transfers, its results
// pass the run, read and output registers; one per cycle while out_stall is low.
// Throughput: one input byte per cycle; a length or end byte stalls only while
// the previous frame's run is still being read out of the two-bank param RAM.
// Reset: synchronous active-low rst_n clears parser phase, run and output
// valids and the header/end registers; the param RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"
module sum_checked_response_deframer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [7:0]                  cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_command,
  output logic [7:0]                       out_function_code,
  output logic [7:0]                       out_channel_id,
  output logic [scrd_pkg::CNT_W-1:0]       out_param_count,
  output logic [scrd_pkg::IDX_W-1:0]       out_param_index,
  output logic [7:0]                       out_param_byte,
  output logic                             out_last
);

  typedef enum logic [3:0] {
    PH_HUNT1 = 4'd0,
    PH_HUNT2 = 4'd1,
    PH_LEN   = 4'd2,
    PH_CMD   = 4'd3,
    PH_FUNC  = 4'd4,
    PH_CHAN  = 4'd5,
    PH_PARAM = 4'd6,
    PH_SUM   = 4'd7,
    PH_END   = 4'd8
  } phase_t;

  localparam logic [8:0] LEN_MAX = 9'(scrd_pkg::PARAM_LIMIT + scrd_pkg::FIXED_BYTES);

  // config
  logic [7:0] hdr1_r, hdr2_r, endm_r;

  // parser
  phase_t                       phase_r, phase_nxt;
  logic [scrd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [scrd_pkg::CNT_W-1:0]   seen_r, seen_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic [7:0]                   sum_rx_r, sum_rx_nxt;
  logic [7:0]                   cmd_r, cmd_nxt, func_r, func_nxt, chan_r, chan_nxt;
  logic                         wr_bank_r, wr_bank_nxt;
  logic                         mem_we;
  logic [scrd_pkg::ADDR_W-1:0]  mem_waddr;
  logic                         start;
  scrd_pkg::frame_meta_t        start_meta;

  // run / readout
  logic                         run_active_r;
  logic                         run_bank_r;
  logic [scrd_pkg::IDX_W-1:0]   run_idx_r;
  scrd_pkg::frame_meta_t        run_meta_r;
  logic                         run_last;
  logic                         issue;

  logic                         s1_v_r;
  scrd_pkg::frame_meta_t        s1_meta_r;
  logic [scrd_pkg::IDX_W-1:0]   s1_idx_r;
  logic                         s1_last_r;
  logic                         s1_zero_r;
  logic [7:0]                   rd_data_r;

  logic                         out_valid_r;
  scrd_pkg::frame_meta_t        out_meta_r;
  logic [scrd_pkg::IDX_W-1:0]   out_idx_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r;
  logic                         out_free;

  logic [7:0] mem [2*scrd_pkg::STORE_DEPTH];

  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = run_active_r && (phase_r == PH_LEN || phase_r == PH_END);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = run_active_r && (!s1_v_r || out_free);
  assign run_last  = (run_meta_r.param_count == '0) ||
                     ({1'b0, run_idx_r} + 5'd1 == run_meta_r.param_count);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    seen_nxt    = seen_r;
    sum_nxt     = sum_r;
    sum_rx_nxt  = sum_rx_r;
    cmd_nxt     = cmd_r;
    func_nxt    = func_r;
    chan_nxt    = chan_r;
    wr_bank_nxt = wr_bank_r;
    mem_we      = 1'b0;
    mem_waddr   = {wr_bank_r, seen_r[scrd_pkg::IDX_W-1:0]};
    start       = 1'b0;
    start_meta  = '{status: scrd_pkg::ST_GOOD, command: cmd_r, function_code: func_r,
                    channel_id: chan_r, param_count: cnt_r};
    if (in_xfer) begin
      unique case (phase_r)
        PH_HUNT2: begin
          phase_nxt = (in_rx_byte == hdr2_r) ? PH_LEN : PH_HUNT1;
        end
        PH_LEN: begin
          if (in_rx_byte < 8'(scrd_pkg::FIXED_BYTES) || {1'b0, in_rx_byte} > LEN_MAX) begin
            phase_nxt  = PH_HUNT1;
            start      = 1'b1;
            start_meta = '{status: scrd_pkg::ST_LEN_ERR, command: 8'd0, function_code: 8'd0,
                           channel_id: 8'd0, param_count: '0};
          end else begin
            cnt_nxt   = scrd_pkg::CNT_W'(in_rx_byte - 8'(scrd_pkg::FIXED_BYTES));
            sum_nxt   = in_rx_byte;
            seen_nxt  = '0;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = PH_FUNC;
        end
        PH_FUNC: begin
          func_nxt  = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = PH_CHAN;
        end
        PH_CHAN: begin
          chan_nxt  = in_rx_byte;
          sum_nxt   = sum_r + in_rx_byte;
          phase_nxt = (cnt_r == '0) ? PH_SUM : PH_PARAM;
        end
        PH_PARAM: begin
          mem_we   = 1'b1;
          sum_nxt  = sum_r + in_rx_byte;
          seen_nxt = seen_r + 5'd1;
          if (seen_nxt >= cnt_r) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          sum_rx_nxt = in_rx_byte;
          phase_nxt  = PH_END;
        end
        PH_END: begin
          phase_nxt   = PH_HUNT1;
          start       = 1'b1;
          wr_bank_nxt = !wr_bank_r;
          if (in_rx_byte != endm_r)  start_meta.status = scrd_pkg::ST_END_ERR;
          else if (sum_rx_r != sum_r) start_meta.status = scrd_pkg::ST_SUM_ERR;
        end
        default: begin
          phase_nxt = (in_rx_byte == hdr1_r) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_rx_byte;
    if (issue)  rd_data_r <= mem[{run_bank_r, run_idx_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r       <= 8'd0;
      hdr2_r       <= 8'd0;
      endm_r       <= 8'd0;
      phase_r      <= PH_HUNT1;
      wr_bank_r    <= 1'b0;
      run_active_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          scrd_pkg::CFG_HDR1: hdr1_r <= cfg_data;
          scrd_pkg::CFG_HDR2: hdr2_r <= cfg_data;
          scrd_pkg::CFG_END:  endm_r <= cfg_data;
          default: ;
        endcase
      end
      phase_r   <= phase_nxt;
      wr_bank_r <= wr_bank_nxt;
      if (start) begin
        run_active_r <= 1'b1;
      end else if (issue && run_last) begin
        run_active_r <= 1'b0;
      end
      if (issue)         s1_v_r <= 1'b1;
      else if (out_free) s1_v_r <= 1'b0;
      if (out_free) out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    seen_r   <= seen_nxt;
    sum_r    <= sum_nxt;
    sum_rx_r <= sum_rx_nxt;
    cmd_r    <= cmd_nxt;
    func_r   <= func_nxt;
    chan_r   <= chan_nxt;
    if (start) begin
      run_bank_r <= wr_bank_r;
      run_idx_r  <= '0;
      run_meta_r <= start_meta;
    end else if (issue) begin
      run_idx_r <= run_idx_r + 1'b1;
    end
    if (issue) begin
      s1_meta_r <= run_meta_r;
      s1_idx_r  <= run_idx_r;
      s1_last_r <= run_last;
      s1_zero_r <= (run_meta_r.param_count == '0);
    end
    if (out_free) begin
      out_meta_r <= s1_meta_r;
      out_idx_r  <= s1_idx_r;
      out_byte_r <= s1_zero_r ? 8'd0 : rd_data_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_meta_r.status;
  assign out_command       = out_meta_r.command;
  assign out_function_code = out_meta_r.function_code;
  assign out_channel_id    = out_meta_r.channel_id;
  assign out_param_count   = out_meta_r.param_count;
  assign out_param_index   = out_idx_r;
  assign out_param_byte    = out_byte_r;
  assign out_last          = out_last_r;

  `SCRD_ASSERT(a_run_idx_range,
    !run_active_r || run_meta_r.param_count == '0 ||
    ({1'b0, run_idx_r} < run_meta_r.param_count),
    "run index past parameter count")
  `SCRD_ASSERT_NEXT(a_s1_holds, s1_v_r && out_valid_r && out_stall,
    s1_v_r, "readout stage dropped a result under stall")
  `SCRD_ASSERT_NEXT(a_end_starts_run, in_valid && !in_stall && phase_r == PH_END,
    run_active_r, "end byte transfer did not start a run")

endmodule
`default_nettype wire

/* tb/sum_checked_response_deframer_unit_tb.sv */
`default_nettype none
module sum_checked_response_deframer_unit_tb;

  typedef logic [7:0] octet_t;

  typedef enum logic [3:0] {
    SEEK_SYNC1, SEEK_SYNC2, TAKE_LEN, TAKE_CMD, TAKE_FUNC,
    TAKE_CHAN, TAKE_PARAM, TAKE_SUM, TAKE_END
  } parse_phase_t;

  typedef struct packed {
    scrd_pkg::status_t                status;
    octet_t                           command;
    octet_t                           function_code;
    octet_t                           channel_id;
    logic [scrd_pkg::CNT_W-1:0]       param_count;
    logic [scrd_pkg::IDX_W-1:0]       param_index;
    octet_t                           param_byte;
    logic                             last;
  } frame_result_t;

  localparam int MAX_FRAME = scrd_pkg::PARAM_LIMIT + scrd_pkg::FIXED_BYTES + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  octet_t                     in_rx_byte = '0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  octet_t                     cfg_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_status;
  octet_t                     out_command;
  octet_t                     out_function_code;
  octet_t                     out_channel_id;
  logic [scrd_pkg::CNT_W-1:0] out_param_count;
  logic [scrd_pkg::IDX_W-1:0] out_param_index;
  octet_t                     out_param_byte;
  logic                       out_last;

  sum_checked_response_deframer_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_command(out_command),
    .out_function_code(out_function_code),
    .out_channel_id(out_channel_id),
    .out_param_count(out_param_count),
    .out_param_index(out_param_index),
    .out_param_byte(out_param_byte),
    .out_last(out_last)
  );

  // deframer prediction state
  octet_t        sync1_val = '0;
  octet_t        sync2_val = '0;
  octet_t        close_val = '0;
  parse_phase_t  parse_phase = SEEK_SYNC1;
  octet_t        frame_len = '0;
  octet_t        params_seen = '0;
  octet_t        run_sum = '0;
  octet_t        cmd_q = '0;
  octet_t        func_q = '0;
  octet_t        chan_q = '0;
  octet_t        sum_rx = '0;
  octet_t        param_buf [scrd_pkg::STORE_DEPTH];

  frame_result_t pending_results [$];
  frame_result_t due;
  octet_t        frame_params [scrd_pkg::PARAM_LIMIT];
  int            fail_count = 0;
  int            bytes_sent = 0;
  int            quiet_cycles = 0;
  bit            gaps_on = 1'b0;
  bit            hold_req = 1'b0;
  int            stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_result(input scrd_pkg::status_t st, input octet_t c,
                                      input octet_t f, input octet_t ch, input int cnt,
                                      input int idx, input octet_t pb, input logic lst);
    frame_result_t r;
    r.status = st;
    r.command = c;
    r.function_code = f;
    r.channel_id = ch;
    r.param_count = scrd_pkg::CNT_W'(cnt);
    r.param_index = scrd_pkg::IDX_W'(idx);
    r.param_byte = pb;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void deframe_byte(input octet_t b);
    int count;
    scrd_pkg::status_t st;
    case (parse_phase)
      SEEK_SYNC2: parse_phase = (b == sync2_val) ? TAKE_LEN : SEEK_SYNC1;
      TAKE_LEN: begin
        if (int'(b) < scrd_pkg::FIXED_BYTES ||
            int'(b) - scrd_pkg::FIXED_BYTES > scrd_pkg::PARAM_LIMIT) begin
          parse_phase = SEEK_SYNC1;
          push_result(scrd_pkg::ST_LEN_ERR, '0, '0, '0, 0, 0, '0, 1'b1);
        end else begin
          frame_len = b;
          run_sum = b;
          params_seen = '0;
          parse_phase = TAKE_CMD;
        end
      end
      TAKE_CMD: begin
        cmd_q = b;
        run_sum = run_sum + b;
        parse_phase = TAKE_FUNC;
      end
      TAKE_FUNC: begin
        func_q = b;
        run_sum = run_sum + b;
        parse_phase = TAKE_CHAN;
      end
      TAKE_CHAN: begin
        chan_q = b;
        run_sum = run_sum + b;
        parse_phase = (int'(frame_len) == scrd_pkg::FIXED_BYTES) ? TAKE_SUM : TAKE_PARAM;
      end
      TAKE_PARAM: begin
        param_buf[params_seen[scrd_pkg::IDX_W-1:0]] = b;
        run_sum = run_sum + b;
        params_seen = params_seen + 8'd1;
        if (int'(params_seen) + scrd_pkg::FIXED_BYTES >= int'(frame_len))
          parse_phase = TAKE_SUM;
      end
      TAKE_SUM: begin
        sum_rx = b;
        parse_phase = TAKE_END;
      end
      TAKE_END: begin
        parse_phase = SEEK_SYNC1;
        count = int'(frame_len) - scrd_pkg::FIXED_BYTES;
        if (count > scrd_pkg::STORE_DEPTH) count = scrd_pkg::STORE_DEPTH;
        if (b != close_val) st = scrd_pkg::ST_END_ERR;
        else if (sum_rx != run_sum) st = scrd_pkg::ST_SUM_ERR;
        else st = scrd_pkg::ST_GOOD;
        if (count == 0) begin
          push_result(st, cmd_q, func_q, chan_q, 0, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < count; i++)
            push_result(st, cmd_q, func_q, chan_q, count, i, param_buf[i], i == count - 1);
        end
      end
      default: parse_phase = (b == sync1_val) ? SEEK_SYNC2 : SEEK_SYNC1;
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: command %0h index %0d",
               out_command, out_param_index);
        fail_count++;
      end else begin
        due = pending_results.pop_front();
        check_field("status", int'(due.status), int'(out_status));
        check_field("command", int'(due.command), int'(out_command));
        check_field("function_code", int'(due.function_code), int'(out_function_code));
        check_field("channel_id", int'(due.channel_id), int'(out_channel_id));
        check_field("param_count", int'(due.param_count), int'(out_param_count));
        check_field("param_index", int'(due.param_index), int'(out_param_index));
        check_field("param_byte", int'(due.param_byte), int'(out_param_byte));
        check_field("last", int'(due.last), int'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver back-pressure: random bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      stall_left = LONG_HOLD;
      hold_req = 1'b0;
    end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // entered and left at a falling edge; valid stays high for the next byte
  task automatic send_byte(input octet_t b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input scrd_pkg::cfg_idx_t idx, input octet_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      scrd_pkg::CFG_HDR1: sync1_val = v;
      scrd_pkg::CFG_HDR2: sync2_val = v;
      default:            close_val = v;
    endcase
    @(negedge clk);
  endtask

  task automatic set_framing(input octet_t h1, input octet_t h2, input octet_t em);
    wait_idle();
    write_reg(scrd_pkg::CFG_HDR1, h1);
    write_reg(scrd_pkg::CFG_HDR2, h2);
    write_reg(scrd_pkg::CFG_END, em);
    cfg_valid <= 1'b0;
  endtask

  // frame_params holds the parameter bytes; cut truncates the frame
  task automatic send_frame(input int count, input octet_t cmd, input octet_t fn,
                            input octet_t ch, input bit bad_sum, input bit bad_end,
                            input int cut);
    octet_t frame_bytes [MAX_FRAME];
    octet_t sum;
    int n;
    frame_bytes[0] = sync1_val;
    frame_bytes[1] = sync2_val;
    frame_bytes[2] = 8'(count + scrd_pkg::FIXED_BYTES);
    frame_bytes[3] = cmd;
    frame_bytes[4] = fn;
    frame_bytes[5] = ch;
    sum = frame_bytes[2] + cmd + fn + ch;
    n = 6;
    for (int i = 0; i < count; i++) begin
      frame_bytes[n] = frame_params[i];
      sum = sum + frame_params[i];
      n++;
    end
    frame_bytes[n] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    frame_bytes[n+1] = bad_end ? (close_val ^ 8'($urandom_range(1, 255))) : close_val;
    n = n + 2;
    for (int i = 0; i < n && i < cut; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic send_random_frame();
    int count;
    int kind;
    count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, scrd_pkg::PARAM_LIMIT) :
                                          $urandom_range(0, 3);
    for (int i = 0; i < count; i++) frame_params[i] = 8'($urandom);
    kind = $urandom_range(0, 15);
    case (kind)
      0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      1: begin
        send_byte(sync1_val);
        send_byte(sync2_val);
        send_byte($urandom_range(0, 1) ?
                  8'($urandom_range(0, scrd_pkg::FIXED_BYTES - 1)) :
                  8'($urandom_range(scrd_pkg::FIXED_BYTES + scrd_pkg::PARAM_LIMIT + 1,
                                    255)));
      end
      2: send_frame(count, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0,
                    $urandom_range(1, count + 7));
      default: send_frame(count, 8'($urandom), 8'($urandom), 8'($urandom),
                          kind == 3 || kind == 5, kind == 4 || kind == 5, MAX_FRAME);
    endcase
  endtask

  task automatic run_random_phase(input int n_bytes);
    int b0;
    b0 = bytes_sent;
    while (bytes_sent - b0 < n_bytes)
      send_random_frame();
  endtask

  // registers still at reset values: all-zero sync and end bytes
  task automatic test_reset_values();
    send_frame(0, 8'hFF, 8'h00, 8'h5A, 1'b0, 1'b0, MAX_FRAME);
  endtask

  task automatic test_header_hunt();
    gaps_on = 1'b1;
    set_framing(8'hAA, 8'h55, 8'h0D);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h54);
  endtask

  task automatic test_bad_length();
    send_byte(sync1_val);
    send_byte(sync2_val);
    send_byte(8'(scrd_pkg::FIXED_BYTES - 1));
    send_byte(sync1_val);
    send_byte(sync2_val);
    send_byte(8'(scrd_pkg::FIXED_BYTES + scrd_pkg::PARAM_LIMIT + 1));
  endtask

  // end marker and checksum both wrong: end marker fault wins
  task automatic test_fault_status();
    frame_params[0] = 8'hFF;
    send_frame(1, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, MAX_FRAME);
  endtask

  task automatic test_random_traffic();
    set_framing(8'($urandom), 8'($urandom), 8'($urandom));
    run_random_phase(8);
    set_framing(8'hFF, 8'hFF, 8'hFF);
    run_random_phase(8);
    set_framing(8'h00, 8'hFF, 8'h00);
    run_random_phase(8);
  endtask

  // long receiver hold while full-size frames keep coming
  task automatic test_input_backpressure();
    wait_idle();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < scrd_pkg::PARAM_LIMIT; i++)
        frame_params[i] = (f == 0) ? 8'hFF : (f == 1) ? 8'h00 : 8'($urandom);
      send_frame(scrd_pkg::PARAM_LIMIT, (f == 0) ? 8'hFF : 8'h00, (f == 0) ? 8'h00 : 8'hFF,
                 8'($urandom), 1'b0, 1'b0, MAX_FRAME);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_header_hunt();
    test_bad_length();
    test_fault_status();
    test_random_traffic();
    test_input_backpressure();
    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
